[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the positional insert queue.
// Each macro expects signals clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PIQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define PIQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/piq_pkg.sv]
// Package for the positional insert queue: sizes, request codes, beat types.
// No dependencies; used by piq_cell and positional_insert_queue_unit.
`timescale 1ns / 1ps

package piq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = 6;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);

    // Request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] payload;
    } req_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] head_data;
        logic              head_valid;
        logic [4:0]        entry_count;
        logic              overflow;
    } rsp_beat_t;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
    } cell_cmd_t;

endpackage

[rtl/piq_cell.sv]
// One storage cell of the queue chain: holds a word, loads new data or
// takes a neighbor's word. Depends on piq_pkg.
`timescale 1ns / 1ps

module piq_cell (
    input  logic                      clk,
    input  piq_pkg::cell_cmd_t        cmd,
    input  logic [piq_pkg::IDX_W-1:0] cell_idx,
    input  logic [piq_pkg::DATA_W-1:0] left_data,
    input  logic [piq_pkg::DATA_W-1:0] right_data,
    input  logic [piq_pkg::DATA_W-1:0] new_data,
    output logic [piq_pkg::DATA_W-1:0] data
);

    logic [piq_pkg::DATA_W-1:0] data_reg;
    logic [piq_pkg::DATA_W-1:0] data_next;

    // Insert: cells above the target take from the left, the target loads.
    // Remove: every cell takes from the right.
    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            piq_pkg::CELL_INSERT:
            begin
                if (cell_idx == cmd.idx)
                    data_next = new_data;
                else if (cell_idx > cmd.idx)
                    data_next = left_data;
            end
            piq_pkg::CELL_REMOVE: data_next = right_data;
            default:              data_next = data_reg;
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/positional_insert_queue_unit.sv]
// Top level of the positional insert queue: control, fill count, cell chain
// and response register. Depends on piq_pkg, piq_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   req channel (req_valid / req_stall / req): one request beat carries
//   req_type (append, insert at position, remove head), a 1-based position
//   and a payload word. rsp channel (rsp_valid / rsp_stall / rsp): one
//   response beat per request with the head word, head valid, entry count
//   and an overflow flag for an append or insert dropped on a full queue.
//   The response is registered and appears in the cycle after the request is taken.
//   Throughput: one request per cycle while the response side is not stalled.
//   Every cell of the chain shifts or loads in the same cycle.
//   The response register decouples the sides: while it holds a beat that
//   is stalled, req_stall is high and no new request is taken; once taken,
//   a new request can enter in that same cycle.
//   Reset empties the queue (count zero) and clears the response valid;
//   stored words are not cleared and are never exposed before written.
//   An empty queue reports head_data zero and head_valid zero.

module positional_insert_queue_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  piq_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output piq_pkg::rsp_beat_t rsp
);

    localparam logic [piq_pkg::CNT_W-1:0] FULL_CNT = piq_pkg::CNT_W'(piq_pkg::DEPTH);

    logic [piq_pkg::CNT_W-1:0] count_reg;
    logic [piq_pkg::CNT_W-1:0] count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    piq_pkg::rsp_beat_t        rsp_reg;
    piq_pkg::rsp_beat_t        rsp_next;

    logic                      accept;
    logic                      full;
    logic                      is_add;
    logic                      do_ins;
    logic                      do_rem;
    logic                      ovf;
    logic [piq_pkg::POS_W-1:0] pos_eff;
    logic [piq_pkg::POS_W-1:0] count_ext;
    logic [piq_pkg::IDX_W-1:0] tgt_idx;
    logic [piq_pkg::DATA_W-1:0] head_next;
    piq_pkg::cell_cmd_t        cmd;
    logic [piq_pkg::DATA_W-1:0] cell_data [piq_pkg::DEPTH];

    // Handshake
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    // Request decode and target slot
    always_comb
    begin
        full      = (count_reg == FULL_CNT);
        is_add    = (req.req_type == piq_pkg::REQ_APPEND) ||
                    (req.req_type == piq_pkg::REQ_INSERT);
        do_ins    = accept && is_add && !full;
        do_rem    = accept && (req.req_type == piq_pkg::REQ_REMOVE) && (count_reg != '0);
        ovf       = is_add && full;
        pos_eff   = (req.position == '0) ? piq_pkg::POS_W'(1) : req.position;
        count_ext = piq_pkg::POS_W'(count_reg);
        if ((req.req_type == piq_pkg::REQ_APPEND) || (count_reg == '0) ||
            (pos_eff > count_ext))
            tgt_idx = count_reg[piq_pkg::IDX_W-1:0];
        else
            tgt_idx = piq_pkg::IDX_W'(pos_eff - piq_pkg::POS_W'(1));
    end

    // Command broadcast to the chain
    always_comb
    begin
        cmd.idx = tgt_idx;
        if (do_ins)
            cmd.op = piq_pkg::CELL_INSERT;
        else if (do_rem)
            cmd.op = piq_pkg::CELL_REMOVE;
        else
            cmd.op = piq_pkg::CELL_HOLD;
    end

    // Cell chain: cell 0 is the head
    genvar gi;
    generate
        for (gi = 0; gi < piq_pkg::DEPTH; gi++)
        begin : g_cell
            logic [piq_pkg::DATA_W-1:0] left_w;
            logic [piq_pkg::DATA_W-1:0] right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = req.payload;
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[gi-1];
            end
            if (gi == piq_pkg::DEPTH - 1)
            begin : g_last
                assign right_w = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[gi+1];
            end
            piq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .cell_idx   (piq_pkg::IDX_W'(gi)),
                .left_data  (left_w),
                .right_data (right_w),
                .new_data   (req.payload),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // Next count and head word
    always_comb
    begin
        count_next = count_reg;
        head_next  = cell_data[0];
        if (do_ins)
        begin
            count_next = count_reg + piq_pkg::CNT_W'(1);
            if (tgt_idx == '0)
                head_next = req.payload;
        end
        else if (do_rem)
        begin
            count_next = count_reg - piq_pkg::CNT_W'(1);
            head_next  = cell_data[1];
        end
    end

    // Response beat
    always_comb
    begin
        rsp_next.head_valid  = (count_next != '0);
        rsp_next.head_data   = (count_next != '0) ? head_next : '0;
        rsp_next.entry_count = 5'(count_next);
        rsp_next.overflow    = ovf;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `PIQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= FULL_CNT)
    `PIQ_ASSERT_IMP(a_ovf_full, rsp_valid_reg && rsp_reg.overflow, rsp_reg.entry_count == 5'(FULL_CNT))
    `PIQ_ASSERT_IMP(a_head_valid, rsp_valid_reg, rsp_reg.head_valid == (rsp_reg.entry_count != '0))
    `PIQ_ASSERT_NXT(a_remove_dec, do_rem, count_reg == $past(count_reg) - piq_pkg::CNT_W'(1))
    `PIQ_ASSERT_NXT(a_count_rsp, accept, rsp_reg.entry_count == 5'(count_reg))

endmodule

[test/positional_insert_queue_unit_tb.sv]
// Testbench for positional_insert_queue_unit: directed and random request beats
// checked against an in-bench model of the ordered queue. Depends on piq_pkg.
`timescale 1ns / 1ps

module positional_insert_queue_unit_tb;

    // Unused request code, must behave as a no-op
    localparam logic [1:0] REQ_NOP = 2'd3;

    localparam int RANDOM_ITEMS  = 1675;
    localparam int HOLD_CYCLES   = 80;
    localparam int MAX_PRINTS    = 60;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    piq_pkg::req_beat_t req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    piq_pkg::rsp_beat_t rsp;

    // Request beats waiting to be driven, and head status the queue must report
    piq_pkg::req_beat_t pending_q[$];
    piq_pkg::rsp_beat_t head_status_q[$];

    // Model of the queue contents
    logic [piq_pkg::DATA_W-1:0] queue_slots [piq_pkg::DEPTH];
    int                         queue_fill = 0;

    int accepted_cnt = 0;
    int err_count    = 0;
    int phase1_end   = 0;
    int phase2_end   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int send_idle_pct;
    int rcv_idle_pct;

    positional_insert_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle rates per phase: slow receiver first, slow sender next, then none
    assign send_idle_pct = (accepted_cnt < phase1_end) ? 14 :
                           (accepted_cnt < phase2_end) ? 85 : 0;
    assign rcv_idle_pct  = (accepted_cnt < phase1_end) ? 85 :
                           (accepted_cnt < phase2_end) ? 14 : 0;

    // Apply one request to the model, return the head status after it
    function automatic piq_pkg::rsp_beat_t apply_request(input piq_pkg::req_beat_t r);
        int                 idx;
        int                 pos;
        piq_pkg::rsp_beat_t o;
        o = '0;
        case (r.req_type) inside
            piq_pkg::REQ_APPEND, piq_pkg::REQ_INSERT:
            begin
                if (queue_fill >= piq_pkg::DEPTH)
                    o.overflow = 1'b1;
                else
                begin
                    idx = queue_fill;
                    if (r.req_type == piq_pkg::REQ_INSERT)
                    begin
                        // position zero means the head; past the tail appends
                        pos = (r.position == '0) ? 1 : int'(r.position);
                        if (pos <= queue_fill)
                            idx = pos - 1;
                    end
                    for (int k = queue_fill; k > idx; k--)
                        queue_slots[k] = queue_slots[k-1];
                    queue_slots[idx] = r.payload;
                    queue_fill++;
                end
            end
            piq_pkg::REQ_REMOVE:
            begin
                if (queue_fill > 0)
                begin
                    for (int k = 0; k + 1 < queue_fill; k++)
                        queue_slots[k] = queue_slots[k+1];
                    queue_fill--;
                end
            end
            default: ;
        endcase
        o.head_valid  = (queue_fill > 0);
        o.head_data   = (queue_fill > 0) ? queue_slots[0] : '0;
        o.entry_count = 5'(queue_fill);
        return o;
    endfunction

    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic push_req(input logic [1:0] kind, input int pos,
                            input logic [piq_pkg::DATA_W-1:0] data);
        piq_pkg::req_beat_t b;
        b.req_type = kind;
        b.position = piq_pkg::POS_W'(pos);
        b.payload  = data;
        pending_q.push_back(b);
    endtask

    // Random beat; mode biases toward filling (0), draining (1) or balance (2)
    task automatic push_random_req(input int mode);
        int                         roll;
        int                         remove_pct;
        int                         pos;
        logic [1:0]                 kind;
        logic [piq_pkg::DATA_W-1:0] data;
        remove_pct = (mode == 0) ? 15 : (mode == 1) ? 70 : 45;
        roll = $urandom_range(99);
        if (roll < 3)
            kind = REQ_NOP;
        else if (roll < 3 + remove_pct)
            kind = piq_pkg::REQ_REMOVE;
        else
            kind = $urandom_range(1) ? piq_pkg::REQ_INSERT : piq_pkg::REQ_APPEND;
        roll = $urandom_range(99);
        if (roll < 60)
            pos = $urandom_range(17);
        else if (roll < 75)
            pos = $urandom_range(1);
        else
            pos = $urandom_range(63);
        roll = $urandom_range(99);
        if (roll < 5)
            data = '0;
        else if (roll < 10)
            data = '1;
        else
            data = $urandom;
        push_req(kind, pos, data);
    endtask

    // Driver: count accepted beats, predict, then offer the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                head_status_q.push_back(apply_request(req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= pending_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random, plus one long hold-off early in the last phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_cnt >= phase2_end + 20)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // Monitor: compare each accepted response beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (head_status_q.size() == 0)
                report_error("response beat with no request outstanding");
            else
            begin
                piq_pkg::rsp_beat_t want;
                want = head_status_q.pop_front();
                if (rsp.head_valid !== want.head_valid)
                    report_error($sformatf("head_valid got %0b want %0b",
                                           rsp.head_valid, want.head_valid));
                if (rsp.head_data !== want.head_data)
                    report_error($sformatf("head_data got %08h want %08h",
                                           rsp.head_data, want.head_data));
                if (rsp.entry_count !== want.entry_count)
                    report_error($sformatf("entry_count got %0d want %0d",
                                           rsp.entry_count, want.entry_count));
                if (rsp.overflow !== want.overflow)
                    report_error($sformatf("overflow got %0b want %0b",
                                           rsp.overflow, want.overflow));
            end
        end
    end

    initial
    begin : stimulus
        int mode;
        int total;

        // Directed: empty-queue cases, position extremes, fill to full, overflow
        push_req(piq_pkg::REQ_REMOVE, 0, 32'h0);
        push_req(REQ_NOP,             5, 32'h1234_5678);
        push_req(piq_pkg::REQ_INSERT, 0, 32'hFFFF_FFFF);
        push_req(piq_pkg::REQ_APPEND, 63, 32'h0000_0000);
        push_req(piq_pkg::REQ_INSERT, 1, 32'hA5A5_A5A5);
        push_req(piq_pkg::REQ_INSERT, 63, 32'h5A5A_5A5A);
        push_req(piq_pkg::REQ_INSERT, 2, $urandom);
        push_req(REQ_NOP,             0, 32'hFFFF_FFFF);
        push_req(piq_pkg::REQ_REMOVE, 42, $urandom);
        push_req(piq_pkg::REQ_INSERT, 5, $urandom);
        for (int i = 0; i < 11; i++)
            push_req((i % 2) ? piq_pkg::REQ_APPEND : piq_pkg::REQ_INSERT, i + 1, $urandom);
        push_req(piq_pkg::REQ_APPEND, 0, 32'hDEAD_BEEF);
        push_req(piq_pkg::REQ_INSERT, 1, 32'hCAFE_F00D);
        push_req(REQ_NOP,             63, $urandom);
        push_req(piq_pkg::REQ_REMOVE, 0, $urandom);
        push_req(piq_pkg::REQ_INSERT, 15, $urandom);

        // Random: bias changes every 40 beats so the queue swings full and empty
        mode = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                mode = $urandom_range(2);
            push_random_req(mode);
        end

        total      = pending_q.size();
        phase1_end = total / 3;
        phase2_end = (2 * total) / 3;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || req_valid)
            @(posedge clk);
        while (head_status_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
